// ===== rtl/core/btnar_pkg.sv =====
// Package for the button autorepeat block: shared types, register indexes and constants.
// No dependencies; used by every module under rtl/core but btnar_queue, by scoped names.
`default_nettype none

package btnar_pkg;

    // Field widths
    localparam int PRESS_BITS = 12;
    localparam int STICK_BITS = 8;
    localparam int TIME_BITS  = 64;
    localparam int MS_BITS    = 16;
    localparam int TPMS_BITS  = 20;
    localparam int PROD_BITS  = MS_BITS + TPMS_BITS;
    localparam int VBTN_BITS  = 16;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = TPMS_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_DLY  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_PER   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS_PER_MS = 2'd3;

    // Register reset values
    localparam logic                 RST_REPEAT_MODE  = 1'b0;
    localparam logic [MS_BITS-1:0]   RST_INITIAL_DLY  = 16'd400;
    localparam logic [MS_BITS-1:0]   RST_REPEAT_PER   = 16'd50;
    localparam logic [TPMS_BITS-1:0] RST_TICKS_PER_MS = 20'd1000;
    localparam logic [PROD_BITS-1:0] RST_DLY_TICKS    = 36'd400000;
    localparam logic [PROD_BITS-1:0] RST_PER_TICKS    = 36'd50000;

    // Command and mode codes
    localparam logic CMD_POLL    = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;
    localparam logic MODE_PLAIN  = 1'b0;
    localparam logic MODE_REPEAT = 1'b1;

    // Stick thresholds
    localparam logic [STICK_BITS-1:0] STICK_LOW  = 8'd32;
    localparam logic [STICK_BITS-1:0] STICK_HIGH = 8'd224;

    // Depth of both decoupling queues
    localparam int QUEUE_DEPTH = 2;

    // What the back end must do with an item
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_POLL_PLAIN,
        KIND_POLL_REPEAT,
        KIND_CLEAR_REPEAT
    } t_kind;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_stick_flags;

    // Classified item passed from front to back
    typedef struct packed {
        t_kind                  kind;
        logic [PRESS_BITS-1:0]  pressed;
        t_stick_flags           flags;
        logic [STICK_BITS-1:0]  stick_x;
        logic [STICK_BITS-1:0]  stick_y;
        logic [TIME_BITS-1:0]   now;
        logic [TIME_BITS-1:0]   sum_delay;
        logic [TIME_BITS-1:0]   sum_period;
    } t_entry;

    typedef struct packed {
        logic [VBTN_BITS-1:0]  button_bits;
        logic [STICK_BITS-1:0] stick_x;
        logic [STICK_BITS-1:0] stick_y;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/btnar_queue.sv =====
// Small flop-based FIFO used to decouple the pipeline sections.
// Depends on nothing; width and depth are parameters.
`default_nettype none

module btnar_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/btnar_front.sv =====
// Front end: config registers, input stage, item classification and deadline sums.
// Depends on btnar_pkg.
`default_nettype none

module btnar_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // config
    input  wire logic                                  i_cfg_we,
    input  wire logic [btnar_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [btnar_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // sample input
    input  wire logic                                  i_push,
    output logic                                       o_full,
    input  wire logic                                  i_command,
    input  wire logic [btnar_pkg::PRESS_BITS-1:0]      i_pressed,
    input  wire logic [btnar_pkg::STICK_BITS-1:0]      i_stick_x,
    input  wire logic [btnar_pkg::STICK_BITS-1:0]      i_stick_y,
    input  wire logic [btnar_pkg::TIME_BITS-1:0]       i_now,
    // towards the command queue
    output logic                                       o_q_push,
    output btnar_pkg::t_entry                          o_q_entry,
    input  wire logic                                  i_q_full
);

    // config registers and precomputed tick products
    logic                                r_repeat_mode, n_repeat_mode;
    logic [btnar_pkg::MS_BITS-1:0]       r_delay_ms,    n_delay_ms;
    logic [btnar_pkg::MS_BITS-1:0]       r_period_ms,   n_period_ms;
    logic [btnar_pkg::TPMS_BITS-1:0]     r_ticks,       n_ticks;
    logic [btnar_pkg::PROD_BITS-1:0]     r_dly_ticks,   n_dly_ticks;
    logic [btnar_pkg::PROD_BITS-1:0]     r_per_ticks,   n_per_ticks;

    // input stage
    logic                                r_stg_valid,   n_stg_valid;
    btnar_pkg::t_kind                    r_kind;
    logic [btnar_pkg::PRESS_BITS-1:0]    r_pressed;
    logic [btnar_pkg::STICK_BITS-1:0]    r_stick_x;
    logic [btnar_pkg::STICK_BITS-1:0]    r_stick_y;
    logic [btnar_pkg::TIME_BITS-1:0]     r_now;

    btnar_pkg::t_kind                    in_kind;
    logic                                accept, stg_adv;

    // Products follow the write data directly, so they are current from the write edge.
    always_comb begin
        n_repeat_mode = r_repeat_mode;
        n_delay_ms    = r_delay_ms;
        n_period_ms   = r_period_ms;
        n_ticks       = r_ticks;
        if (i_cfg_we) begin
            case (i_cfg_index)
                btnar_pkg::CFG_REPEAT_MODE:  n_repeat_mode = i_cfg_data[0];
                btnar_pkg::CFG_INITIAL_DLY:  n_delay_ms    = i_cfg_data[btnar_pkg::MS_BITS-1:0];
                btnar_pkg::CFG_REPEAT_PER:   n_period_ms   = i_cfg_data[btnar_pkg::MS_BITS-1:0];
                btnar_pkg::CFG_TICKS_PER_MS: n_ticks       = i_cfg_data;
                default: ;
            endcase
        end
        n_dly_ticks = btnar_pkg::PROD_BITS'(n_delay_ms) * btnar_pkg::PROD_BITS'(n_ticks);
        n_per_ticks = btnar_pkg::PROD_BITS'(n_period_ms) * btnar_pkg::PROD_BITS'(n_ticks);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_mode <= btnar_pkg::RST_REPEAT_MODE;
            r_delay_ms    <= btnar_pkg::RST_INITIAL_DLY;
            r_period_ms   <= btnar_pkg::RST_REPEAT_PER;
            r_ticks       <= btnar_pkg::RST_TICKS_PER_MS;
            r_dly_ticks   <= btnar_pkg::RST_DLY_TICKS;
            r_per_ticks   <= btnar_pkg::RST_PER_TICKS;
        end else begin
            r_repeat_mode <= n_repeat_mode;
            r_delay_ms    <= n_delay_ms;
            r_period_ms   <= n_period_ms;
            r_ticks       <= n_ticks;
            r_dly_ticks   <= n_dly_ticks;
            r_per_ticks   <= n_per_ticks;
        end
    end

    // classification: a clear in plain mode has no effect at all
    always_comb begin
        case ({i_command, r_repeat_mode})
            {btnar_pkg::CMD_POLL,  btnar_pkg::MODE_PLAIN}:  in_kind = btnar_pkg::KIND_POLL_PLAIN;
            {btnar_pkg::CMD_POLL,  btnar_pkg::MODE_REPEAT}: in_kind = btnar_pkg::KIND_POLL_REPEAT;
            {btnar_pkg::CMD_CLEAR, btnar_pkg::MODE_REPEAT}: in_kind = btnar_pkg::KIND_CLEAR_REPEAT;
            default:                                        in_kind = btnar_pkg::KIND_NONE;
        endcase
    end

    assign stg_adv = r_stg_valid && !i_q_full;
    assign o_full  = r_stg_valid && i_q_full;
    assign accept  = i_push && !o_full;

    always_comb begin
        n_stg_valid = r_stg_valid;
        if (accept) begin
            n_stg_valid = 1'b1;
        end else if (stg_adv) begin
            n_stg_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_kind      <= btnar_pkg::KIND_NONE;
        end else begin
            r_stg_valid <= n_stg_valid;
            if (accept) begin
                r_kind <= in_kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pressed <= i_pressed;
            r_stick_x <= i_stick_x;
            r_stick_y <= i_stick_y;
            r_now     <= i_now;
        end
    end

    // from the input stage registers: stick flags and the two candidate deadlines (wrap at 64 bits)
    always_comb begin
        o_q_entry.kind       = r_kind;
        o_q_entry.pressed    = r_pressed;
        o_q_entry.flags.up   = (r_stick_y < btnar_pkg::STICK_LOW);
        o_q_entry.flags.down = (r_stick_y >= btnar_pkg::STICK_HIGH);
        o_q_entry.flags.left = (r_stick_x < btnar_pkg::STICK_LOW);
        o_q_entry.flags.right = (r_stick_x >= btnar_pkg::STICK_HIGH);
        o_q_entry.stick_x    = r_stick_x;
        o_q_entry.stick_y    = r_stick_y;
        o_q_entry.now        = r_now;
        o_q_entry.sum_delay  = r_now + btnar_pkg::TIME_BITS'(r_dly_ticks);
        o_q_entry.sum_period = r_now + btnar_pkg::TIME_BITS'(r_per_ticks);
    end

    assign o_q_push = stg_adv && (r_kind != btnar_pkg::KIND_NONE);

endmodule

`default_nettype wire

// ===== rtl/core/btnar_back.sv =====
// Back end: per-button fire-time registers, fire decisions and result assembly.
// Depends on btnar_pkg.
`default_nettype none

module btnar_back #(
    parameter int NUM_BUTTONS = 12
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // from the command queue
    input  wire logic                i_q_valid,
    input  wire btnar_pkg::t_entry   i_q_entry,
    output logic                     o_q_pop,
    // towards the result queue
    output logic                     o_res_push,
    output btnar_pkg::t_result       o_res,
    input  wire logic                i_res_full
);

    // buttons past the pressed field never fire, so they need no timer
    localparam int NB = (NUM_BUTTONS < btnar_pkg::PRESS_BITS) ? NUM_BUTTONS
                                                              : btnar_pkg::PRESS_BITS;

    logic [btnar_pkg::TIME_BITS-1:0]  r_timer [NB];
    logic [btnar_pkg::TIME_BITS-1:0]  n_timer [NB];
    logic [NB-1:0]                    t_zero;
    logic [NB-1:0]                    due;
    logic [btnar_pkg::PRESS_BITS-1:0] fire;
    logic                             take;
    logic                             is_clear;

    assign is_clear = (i_q_entry.kind == btnar_pkg::KIND_CLEAR_REPEAT);
    assign take     = i_q_valid && (is_clear || !i_res_full);
    assign o_q_pop  = take;

    for (genvar g = 0; g < NB; g++) begin : g_cmp
        assign t_zero[g] = (r_timer[g] == '0);
        assign due[g]    = t_zero[g] || (i_q_entry.now >= r_timer[g]);
    end

    always_comb begin
        fire = '0;
        for (int i = 0; i < NB; i++) begin
            n_timer[i] = r_timer[i];
            case (i_q_entry.kind)
                btnar_pkg::KIND_POLL_PLAIN: begin
                    fire[i] = i_q_entry.pressed[i];
                end
                btnar_pkg::KIND_POLL_REPEAT: begin
                    if (!i_q_entry.pressed[i]) begin
                        n_timer[i] = '0;
                    end else if (due[i]) begin
                        fire[i]    = 1'b1;
                        n_timer[i] = t_zero[i] ? i_q_entry.sum_delay : i_q_entry.sum_period;
                    end
                end
                btnar_pkg::KIND_CLEAR_REPEAT: begin
                    n_timer[i] = i_q_entry.pressed[i] ? i_q_entry.sum_delay : '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NB; i++) begin
                r_timer[i] <= '0;
            end
        end else if (take) begin
            for (int i = 0; i < NB; i++) begin
                r_timer[i] <= n_timer[i];
            end
        end
    end

    assign o_res_push = take && !is_clear;

    always_comb begin
        o_res.button_bits = {i_q_entry.flags.right, i_q_entry.flags.left,
                             i_q_entry.flags.down,  i_q_entry.flags.up, fire};
        o_res.stick_x     = i_q_entry.stick_x;
        o_res.stick_y     = i_q_entry.stick_y;
    end

endmodule

`default_nettype wire

// ===== rtl/core/button_autorepeat_with_stick_directions.sv =====
// Top level of the gamepad button autorepeat block with stick direction flags.
// Depends on btnar_pkg, btnar_front, btnar_queue and btnar_back.
//
//  Channel   | Direction | Handshake              | Payload
//  ----------+-----------+------------------------+-------------------------------------------
//  sample    | in        | push / full            | i_command, i_pressed, i_stick_x/y, i_now
//  result    | out       | empty / pop            | o_button_bits, o_stick_x_out/y_out
//  config    | in        | i_cfg_we (no wait)     | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result side keeps popping. A poll item passes
// the input stage, the command queue and the result queue to the result ports. A clear
// item updates the timers when the back end pops it and gives no result.
// Synchronous active-low reset empties both queues, zeroes all fire-time registers
// and loads the register defaults (plain mode, 400 ms, 50 ms, 1000 ticks/ms).
// A stalled result side fills both queues and the input stage, then raises full.
`default_nettype none

module button_autorepeat_with_stick_directions #(
    parameter int NUM_BUTTONS = 12
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [btnar_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [btnar_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // sample items
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic                                 i_command,
    input  wire logic [btnar_pkg::PRESS_BITS-1:0]     i_pressed,
    input  wire logic [btnar_pkg::STICK_BITS-1:0]     i_stick_x,
    input  wire logic [btnar_pkg::STICK_BITS-1:0]     i_stick_y,
    input  wire logic [btnar_pkg::TIME_BITS-1:0]      i_now,
    // result items
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic      [btnar_pkg::VBTN_BITS-1:0]      o_button_bits,
    output logic      [btnar_pkg::STICK_BITS-1:0]     o_stick_x_out,
    output logic      [btnar_pkg::STICK_BITS-1:0]     o_stick_y_out
);

    localparam int ENTRY_W = $bits(btnar_pkg::t_entry);
    localparam int RES_W   = $bits(btnar_pkg::t_result);

    // front -> command queue
    logic                   cq_push, cq_full, cq_empty, cq_pop;
    btnar_pkg::t_entry      front_entry;
    logic [ENTRY_W-1:0]     cq_data;
    btnar_pkg::t_entry      back_entry;

    // back -> result queue
    logic                   rq_push, rq_full;
    btnar_pkg::t_result     back_res;
    logic [RES_W-1:0]       rq_data;
    btnar_pkg::t_result     out_res;

    // Front: holds config, registers the sample, classifies it and forms deadlines.
    btnar_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_command   (i_command),
        .i_pressed   (i_pressed),
        .i_stick_x   (i_stick_x),
        .i_stick_y   (i_stick_y),
        .i_now       (i_now),
        .o_q_push    (cq_push),
        .o_q_entry   (front_entry),
        .i_q_full    (cq_full)
    );

    // Command queue: lets the front keep taking samples while the back waits.
    btnar_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (btnar_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_data  (front_entry),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_data  (cq_data),
        .o_empty (cq_empty)
    );

    assign back_entry = btnar_pkg::t_entry'(cq_data);

    // Back: per-button fire-time state and the fire decisions.
    btnar_back #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (!cq_empty),
        .i_q_entry  (back_entry),
        .o_q_pop    (cq_pop),
        .o_res_push (rq_push),
        .o_res      (back_res),
        .i_res_full (rq_full)
    );

    // Result queue: output register stage, the consumer may stall freely.
    btnar_queue #(
        .WIDTH (RES_W),
        .DEPTH (btnar_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (back_res),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_data),
        .o_empty (empty)
    );

    assign out_res       = btnar_pkg::t_result'(rq_data);
    assign o_button_bits = out_res.button_bits;
    assign o_stick_x_out = out_res.stick_x;
    assign o_stick_y_out = out_res.stick_y;

endmodule

`default_nettype wire

// ===== bench/btnar_autorepeat_checker.sv =====
`timescale 1ns / 1ps
// Checker for the button autorepeat block: follows the register writes and both
// channels, predicts each gamepad report and compares it. Depends on btnar_pkg.
module btnar_autorepeat_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [btnar_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [btnar_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                                push,
    input  wire logic                                full,
    input  wire logic                                i_command,
    input  wire logic [btnar_pkg::PRESS_BITS-1:0]    i_pressed,
    input  wire logic [btnar_pkg::STICK_BITS-1:0]    i_stick_x,
    input  wire logic [btnar_pkg::STICK_BITS-1:0]    i_stick_y,
    input  wire logic [btnar_pkg::TIME_BITS-1:0]     i_now,
    input  wire logic                                empty,
    input  wire logic                                pop,
    input  wire logic [btnar_pkg::VBTN_BITS-1:0]     i_button_bits,
    input  wire logic [btnar_pkg::STICK_BITS-1:0]    i_stick_x_out,
    input  wire logic [btnar_pkg::STICK_BITS-1:0]    i_stick_y_out,
    output int                                       o_fail_count,
    output int                                       o_waiting
);

    localparam int FLAG_UP    = 12;
    localparam int FLAG_DOWN  = 13;
    localparam int FLAG_LEFT  = 14;
    localparam int FLAG_RIGHT = 15;

    logic                            mode;
    logic [btnar_pkg::MS_BITS-1:0]   delay_ms;
    logic [btnar_pkg::MS_BITS-1:0]   period_ms;
    logic [btnar_pkg::TPMS_BITS-1:0] tpms;
    logic [btnar_pkg::TIME_BITS-1:0] fire_at [btnar_pkg::PRESS_BITS];
    btnar_pkg::t_result              expected_reports [$];
    int                              reports_seen;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic predict_report(input logic cmd,
                                  input logic [btnar_pkg::PRESS_BITS-1:0] held,
                                  input logic [btnar_pkg::STICK_BITS-1:0] sx,
                                  input logic [btnar_pkg::STICK_BITS-1:0] sy,
                                  input logic [btnar_pkg::TIME_BITS-1:0] t_now);
        logic [btnar_pkg::TIME_BITS-1:0] delay_ticks;
        logic [btnar_pkg::TIME_BITS-1:0] period_ticks;
        btnar_pkg::t_result              rep;
        int                              b;
        delay_ticks  = {48'd0, delay_ms} * {44'd0, tpms};
        period_ticks = {48'd0, period_ms} * {44'd0, tpms};
        if (cmd == btnar_pkg::CMD_CLEAR) begin
            // clear arms held buttons in autorepeat mode, gives no report
            if (mode == btnar_pkg::MODE_REPEAT)
                for (b = 0; b < btnar_pkg::PRESS_BITS; b++)
                    fire_at[b] = held[b] ? t_now + delay_ticks : '0;
        end else begin
            rep = '0;
            for (b = 0; b < btnar_pkg::PRESS_BITS; b++) begin
                if (mode == btnar_pkg::MODE_PLAIN) begin
                    rep.button_bits[b] = held[b];
                end else if (held[b]) begin
                    // zero timer means released: first press fires at once
                    if (fire_at[b] == '0 || t_now >= fire_at[b]) begin
                        rep.button_bits[b] = 1'b1;
                        fire_at[b] = t_now + ((fire_at[b] != '0) ? period_ticks
                                                                  : delay_ticks);
                    end
                end else begin
                    fire_at[b] = '0;
                end
            end
            if (sy < btnar_pkg::STICK_LOW)
                rep.button_bits[FLAG_UP] = 1'b1;
            else if (sy >= btnar_pkg::STICK_HIGH)
                rep.button_bits[FLAG_DOWN] = 1'b1;
            if (sx < btnar_pkg::STICK_LOW)
                rep.button_bits[FLAG_LEFT] = 1'b1;
            else if (sx >= btnar_pkg::STICK_HIGH)
                rep.button_bits[FLAG_RIGHT] = 1'b1;
            rep.stick_x = sx;
            rep.stick_y = sy;
            expected_reports.push_back(rep);
        end
    endtask

    always @(posedge i_clk) begin
        btnar_pkg::t_result exp_rep;
        if (!i_rst_n) begin
            mode         = btnar_pkg::RST_REPEAT_MODE;
            delay_ms     = btnar_pkg::RST_INITIAL_DLY;
            period_ms    = btnar_pkg::RST_REPEAT_PER;
            tpms         = btnar_pkg::RST_TICKS_PER_MS;
            o_fail_count = 0;
            reports_seen = 0;
            for (int b = 0; b < btnar_pkg::PRESS_BITS; b++)
                fire_at[b] = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    btnar_pkg::CFG_REPEAT_MODE:  mode      = i_cfg_data[0];
                    btnar_pkg::CFG_INITIAL_DLY:  delay_ms  = i_cfg_data[btnar_pkg::MS_BITS-1:0];
                    btnar_pkg::CFG_REPEAT_PER:   period_ms = i_cfg_data[btnar_pkg::MS_BITS-1:0];
                    btnar_pkg::CFG_TICKS_PER_MS: tpms = i_cfg_data[btnar_pkg::TPMS_BITS-1:0];
                    default: ;
                endcase
            end
            // a report leaving at this edge can never be the item entering now
            if (pop && !empty) begin
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    report_mismatch($sformatf("report %0d arrived with none expected",
                                              reports_seen));
                end else begin
                    exp_rep = expected_reports.pop_front();
                    if (i_button_bits !== exp_rep.button_bits)
                        report_mismatch($sformatf("report %0d button_bits: exp %h got %h",
                            reports_seen, exp_rep.button_bits, i_button_bits));
                    if (i_stick_x_out !== exp_rep.stick_x)
                        report_mismatch($sformatf("report %0d stick_x_out: exp %h got %h",
                            reports_seen, exp_rep.stick_x, i_stick_x_out));
                    if (i_stick_y_out !== exp_rep.stick_y)
                        report_mismatch($sformatf("report %0d stick_y_out: exp %h got %h",
                            reports_seen, exp_rep.stick_y, i_stick_y_out));
                end
            end
            if (push && !full)
                predict_report(i_command, i_pressed, i_stick_x, i_stick_y, i_now);
        end
        o_waiting = expected_reports.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the button autorepeat bench: clock, reset, sample stimulus, result stalls,
// watchdog and verdict. Depends on btnar_pkg, the block and btnar_autorepeat_checker.
module testbench;

    // No acceptance on either side for this long means the block has hung.
    // Slowest legal stretch: a receiver stall or the settle plus four register
    // writes, so this is many times over.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 110;
    // a clear may still be in flight after the last report
    localparam int SETTLE_CYCLES   = 6;
    localparam int PRESSURE_PHASE  = 5;
    localparam int TB              = btnar_pkg::TIME_BITS;
    localparam int DB              = btnar_pkg::CFG_DATA_BITS;
    localparam int PB              = btnar_pkg::PRESS_BITS;
    localparam logic [TB-1:0] TIME_MAX = '1;

    typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_BURSTY} t_rx_style;

    logic                                  i_clk       = 1'b0;
    logic                                  i_rst_n     = 1'b0;
    logic                                  i_cfg_we    = 1'b0;
    logic [btnar_pkg::CFG_IDX_BITS-1:0]    i_cfg_index = '0;
    logic [DB-1:0]                         i_cfg_data  = '0;
    logic                                  push        = 1'b0;
    logic                                  i_command   = btnar_pkg::CMD_POLL;
    logic [PB-1:0]                         i_pressed   = '0;
    logic [btnar_pkg::STICK_BITS-1:0]      i_stick_x   = '0;
    logic [btnar_pkg::STICK_BITS-1:0]      i_stick_y   = '0;
    logic [TB-1:0]                         i_now       = '0;
    logic                                  pop         = 1'b0;
    logic                                  full;
    logic                                  empty;
    logic [btnar_pkg::VBTN_BITS-1:0]       o_button_bits;
    logic [btnar_pkg::STICK_BITS-1:0]      o_stick_x_out;
    logic [btnar_pkg::STICK_BITS-1:0]      o_stick_y_out;
    int                                    fail_count;
    int                                    reports_waiting;
    int                                    idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    button_autorepeat_with_stick_directions u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_command         (i_command),
        .i_pressed         (i_pressed),
        .i_stick_x         (i_stick_x),
        .i_stick_y         (i_stick_y),
        .i_now             (i_now),
        .empty             (empty),
        .pop               (pop),
        .o_button_bits     (o_button_bits),
        .o_stick_x_out     (o_stick_x_out),
        .o_stick_y_out     (o_stick_y_out)
    );

    btnar_autorepeat_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_command         (i_command),
        .i_pressed         (i_pressed),
        .i_stick_x         (i_stick_x),
        .i_stick_y         (i_stick_y),
        .i_now             (i_now),
        .empty             (empty),
        .pop               (pop),
        .i_button_bits     (o_button_bits),
        .i_stick_x_out     (o_stick_x_out),
        .i_stick_y_out     (o_stick_y_out),
        .o_fail_count      (fail_count),
        .o_waiting         (reports_waiting)
    );

    // ---------------------------------------------------------------------------
    // Receiver: pop changes on the falling edge. The style of stalling is drawn
    // anew at random, so stalls land on every phase of the pipeline and there
    // are long stretches with pop held high as well.
    // ---------------------------------------------------------------------------
    t_rx_style rx_style    = RX_STREAM;
    int        rx_left     = 0;
    int        stall_run   = 0;
    logic      stall_low   = 1'b0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_style)
            RX_STREAM: pop <= 1'b1;
            RX_COIN:   pop <= 1'($urandom_range(0, 1));
            RX_SPARSE: pop <= ($urandom_range(0, 7) == 0);
            default: begin
                // long stalls broken by short bursts of pops
                if (stall_run == 0) begin
                    stall_low = !stall_low;
                    stall_run = stall_low ? $urandom_range(5, 30) : $urandom_range(1, 8);
                end else begin
                    stall_run--;
                end
                pop <= !stall_low;
            end
        endcase
    end

    // ---------------------------------------------------------------------------
    // Watchdog: counts cycles with no item accepted on either side.
    // ---------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------------
    // Sender helpers. All of them are entered and left at a falling edge.
    // ---------------------------------------------------------------------------

    // Offer one sample and hold it until the block takes it. full is read just
    // after the rising edge, i.e. the value the edge itself saw.
    task automatic send_sample(input logic cmd, input logic [PB-1:0] held,
                               input logic [btnar_pkg::STICK_BITS-1:0] sx,
                               input logic [btnar_pkg::STICK_BITS-1:0] sy,
                               input logic [TB-1:0] t_now);
        push      <= 1'b1;
        i_command <= cmd;
        i_pressed <= held;
        i_stick_x <= sx;
        i_stick_y <= sy;
        i_now     <= t_now;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending, let every report drain, then give an in-flight clear time
    // to land before any register is touched.
    task automatic settle();
        push <= 1'b0;
        while (reports_waiting != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write; the enable drops between writes.
    task automatic write_reg(input logic [btnar_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [DB-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random 16-bit register value: extremes, tiny, typical, and now and then
    // garbage in the upper bits of the write data, which must be dropped.
    function automatic logic [DB-1:0] pick_ms();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 20'h0FFFF;
            2:       return DB'($urandom_range(1, 20));
            3:       return DB'($urandom_range(0, 20'hFFFFF));
            default: return DB'($urandom_range(1, 500));
        endcase
    endfunction

    function automatic logic [DB-1:0] pick_tpms();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 20'd1;
            2:       return 20'hFFFFF;
            3:       return 20'd1000000;
            4:       return 20'd1000;
            default: return DB'($urandom_range(1, 5000));
        endcase
    endfunction

    // ---------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------
    initial begin
        logic [DB-1:0]  mode_w, delay_w, period_w, tpms_w;
        logic [TB-1:0]  t0, t_now, dly_ticks, per_ticks, step, big;
        logic [PB-1:0]  held_mask, pressed;
        logic           cmd;
        logic           gapless;
        logic           drain;
        int             burst_left;
        int             sel;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Plain mode out of reset: mask extremes and every stick threshold
        // on both sides; a clear in plain mode must give no report.
        send_sample(btnar_pkg::CMD_POLL,  12'h000,   8'd0, 8'd255, 64'd0);
        send_sample(btnar_pkg::CMD_POLL,  12'hFFF,  8'd31,  8'd32, 64'd1);
        send_sample(btnar_pkg::CMD_POLL,  12'h555,  8'd32,  8'd31, 64'd2);
        send_sample(btnar_pkg::CMD_POLL,  12'hAAA, 8'd223, 8'd224, TIME_MAX);
        send_sample(btnar_pkg::CMD_POLL,  12'h800, 8'd224, 8'd223, 64'd5);
        send_sample(btnar_pkg::CMD_CLEAR, 12'hFFF, 8'd128, 8'd128, 64'd6);
        send_sample(btnar_pkg::CMD_POLL,  12'h001, 8'd255, 8'd128, 64'd6);

        // Autorepeat with the reset timing (400 ms, 50 ms, 1000 ticks/ms):
        // first press, one tick short of the delay, the delay exactly, then
        // the period; time stepping backwards; a clear arming held buttons.
        settle();
        write_reg(btnar_pkg::CFG_REPEAT_MODE, DB'(btnar_pkg::MODE_REPEAT));
        t0 = 64'd1000;
        send_sample(btnar_pkg::CMD_POLL,  12'h001, 8'd128, 8'd128, t0);
        send_sample(btnar_pkg::CMD_POLL,  12'h003, 8'd128, 8'd128, t0 + 64'd399999);
        send_sample(btnar_pkg::CMD_POLL,  12'h003, 8'd128, 8'd128, t0 + 64'd400000);
        send_sample(btnar_pkg::CMD_POLL,  12'h001, 8'd128, 8'd128, t0 + 64'd450000);
        send_sample(btnar_pkg::CMD_POLL,  12'h003, 8'd128, 8'd128, t0 + 64'd100);
        send_sample(btnar_pkg::CMD_CLEAR, 12'h002, 8'd128, 8'd128, t0 + 64'd500000);
        send_sample(btnar_pkg::CMD_POLL,  12'h003, 8'd128, 8'd128, t0 + 64'd500000);
        send_sample(btnar_pkg::CMD_POLL,  12'hFFF, 8'd128, 8'd128, t0 + 64'd900000);
        // next fire time wrapping to exactly zero reads back as released, so
        // the same poll fires again; a wrap to non-zero is not released but lies below now, so it fires too
        send_sample(btnar_pkg::CMD_POLL,  12'h000, 8'd128, 8'd128, t0 + 64'd900001);
        send_sample(btnar_pkg::CMD_POLL,  12'h008, 8'd128, 8'd128, 64'd0 - 64'd400000);
        send_sample(btnar_pkg::CMD_POLL,  12'h008, 8'd128, 8'd128, 64'd0 - 64'd400000);
        send_sample(btnar_pkg::CMD_POLL,  12'h008, 8'd128, 8'd128, TIME_MAX);
        send_sample(btnar_pkg::CMD_POLL,  12'h008, 8'd128, 8'd128, TIME_MAX);

        // Zero ticks per ms and zero delay: every sum equals now, so a held button, once
        // it has fired, fires on each poll, and a clear at time zero releases all.
        settle();
        write_reg(btnar_pkg::CFG_TICKS_PER_MS, '0);
        write_reg(btnar_pkg::CFG_INITIAL_DLY, '0);
        write_reg(btnar_pkg::CFG_REPEAT_PER, 20'h0FFFF);
        send_sample(btnar_pkg::CMD_POLL,  12'hFFF, 8'd128, 8'd128, 64'd10);
        send_sample(btnar_pkg::CMD_POLL,  12'hFFF, 8'd128, 8'd128, 64'd10);
        send_sample(btnar_pkg::CMD_CLEAR, 12'hFFF, 8'd128, 8'd128, 64'd0);
        send_sample(btnar_pkg::CMD_POLL,  12'h0F0, 8'd128, 8'd128, 64'd0);

        // Largest delay, period and tick rate the registers hold.
        settle();
        write_reg(btnar_pkg::CFG_INITIAL_DLY, 20'h0FFFF);
        write_reg(btnar_pkg::CFG_TICKS_PER_MS, 20'hFFFFF);
        big = 64'd65535 * 64'd1048575;
        send_sample(btnar_pkg::CMD_POLL,  12'hFFF, 8'd128, 8'd128, 64'd5);
        send_sample(btnar_pkg::CMD_POLL,  12'hFFF, 8'd128, 8'd128, 64'd5 + big - 64'd1);
        send_sample(btnar_pkg::CMD_POLL,  12'hFFF, 8'd128, 8'd128, 64'd5 + big);

        // Random phases. Each sets all four registers, then plays a held-button
        // sequence with time stepping about the delay and period so that the
        // repeat logic is exercised, mixed with some noise.
        burst_left = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            mode_w   = (phase % 4 == 3) ? DB'(btnar_pkg::MODE_PLAIN)
                                        : DB'(btnar_pkg::MODE_REPEAT);
            if ($urandom_range(0, 3) == 0)
                mode_w = {DB'($urandom_range(0, 20'hFFFFF)) & ~20'd1} | mode_w;
            delay_w  = pick_ms();
            period_w = pick_ms();
            tpms_w   = pick_tpms();
            write_reg(btnar_pkg::CFG_REPEAT_MODE, mode_w);
            write_reg(btnar_pkg::CFG_INITIAL_DLY, delay_w);
            write_reg(btnar_pkg::CFG_REPEAT_PER, period_w);
            write_reg(btnar_pkg::CFG_TICKS_PER_MS, tpms_w);
            dly_ticks = {48'd0, delay_w[btnar_pkg::MS_BITS-1:0]} * {44'd0, tpms_w};
            per_ticks = {48'd0, period_w[btnar_pkg::MS_BITS-1:0]} * {44'd0, tpms_w};

            // start small, anywhere, or just short of the 64-bit wrap
            case ($urandom_range(0, 2))
                0:       t_now = 64'($urandom_range(0, 1000));
                1:       t_now = {$urandom, $urandom};
                default: t_now = TIME_MAX - 64'($urandom_range(0, 2000000));
            endcase
            held_mask = PB'($urandom_range(0, 4095));
            gapless   = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // once in the run, hold off until the block has drained
                drain = (phase == PRESSURE_PHASE && k == ITEMS_PER_PHASE / 2);
                if (burst_left == 0 || drain) begin
                    if (!gapless || drain) begin
                        push <= 1'b0;
                        if (drain)
                            while (reports_waiting != 0)
                                @(negedge i_clk);
                        repeat ($urandom_range(1, 8)) @(negedge i_clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;

                cmd = ($urandom_range(0, 11) == 0) ? btnar_pkg::CMD_CLEAR
                                                   : btnar_pkg::CMD_POLL;
                if ($urandom_range(0, 3) == 0)
                    held_mask ^= PB'(1 << $urandom_range(0, PB - 1));

                sel = $urandom_range(0, 99);
                pressed = (sel < 4) ? PB'($urandom_range(0, 4095)) : held_mask;
                if (sel >= 4 && sel < 7) begin
                    t_now = t_now - 64'($urandom_range(1, 100000));   // backwards
                end else if (sel == 7) begin
                    t_now = {$urandom, $urandom};
                end else begin
                    case ($urandom_range(0, 9))
                        0:       step = '0;
                        1:       step = 64'($urandom_range(1, 3));
                        2, 3:    step = dly_ticks * 64'($urandom_range(0, 12)) / 64'd8;
                        default: step = per_ticks * 64'($urandom_range(0, 12)) / 64'd8;
                    endcase
                    t_now = t_now + step + 64'($urandom_range(0, 1));
                end
                send_sample(cmd, pressed, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), t_now);
            end
        end

        settle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/btnar_pkg.sv
rtl/core/btnar_queue.sv
rtl/core/btnar_front.sv
rtl/core/btnar_back.sv
rtl/core/button_autorepeat_with_stick_directions.sv
bench/btnar_autorepeat_checker.sv
bench/testbench.sv
